>>> rtl/utf16_to_utf8_transcoder_macros.svh
// assertion macros for the utf-16 to utf-8 transcoder
// used by the top level only; expects clk_i and rst_ni in scope
`ifndef UTF16_TO_UTF8_TRANSCODER_MACROS_SVH
`define UTF16_TO_UTF8_TRANSCODER_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every edge outside reset
`define U16_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen outside reset
`define U16_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define U16_ASSERT(lbl, prop, msg)
`define U16_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

>>> rtl/u16u8_pkg.sv
// shared types, constants and byte encoder for the utf-16 to utf-8 transcoder
// no dependencies
package u16u8_pkg;

  // utf-8 lead and continuation markers
  localparam logic [7:0] Lead2 = 8'hC0;
  localparam logic [7:0] Lead3 = 8'hE0;
  localparam logic [7:0] Lead4 = 8'hF0;
  localparam logic [7:0] Cont  = 8'h80;

  // surrogate prefixes (top six bits of the unit)
  localparam logic [5:0] HighPrefix = 6'b110110;
  localparam logic [5:0] LowPrefix  = 6'b110111;

  // code point limits for one and two byte forms
  localparam logic [15:0] Max1Byte = 16'h007F;
  localparam logic [15:0] Max2Byte = 16'h07FF;

  // offset of the supplementary planes
  localparam logic [20:0] SuppBase = 21'h10000;

  // sequence lengths minus one
  localparam logic [1:0] Len1 = 2'd0;
  localparam logic [1:0] Len2 = 2'd1;
  localparam logic [1:0] Len3 = 2'd2;
  localparam logic [1:0] Len4 = 2'd3;

  // queue depth between front and back, power of two
  localparam int QDepth = 2;
  localparam int QAw    = $clog2(QDepth);
  localparam int QCw    = $clog2(QDepth + 1);

  // one queued job: an optional flushed high surrogate, then an optional code point
  typedef struct packed {
    logic        pre_valid;
    logic [9:0]  pre_bits;
    logic        cur_valid;
    logic [20:0] cp;
    logic [1:0]  len_m1;
    logic        last;
  } entry_t;

  // byte idx of the utf-8 form of cp, which is len_m1 + 1 bytes long
  function automatic logic [7:0] enc_byte(logic [20:0] cp, logic [1:0] len_m1,
                                          logic [1:0] idx);
    logic [1:0] k;
    logic [5:0] six;
    logic [7:0] b;
    k = len_m1 - idx;
    unique case (k)
      2'd0:    six = cp[5:0];
      2'd1:    six = cp[11:6];
      2'd2:    six = cp[17:12];
      default: six = {3'b000, cp[20:18]};
    endcase
    if (idx == 2'd0) begin
      unique case (len_m1)
        Len1:    b = {1'b0, cp[6:0]};
        Len2:    b = Lead2 | {3'b000, cp[10:6]};
        Len3:    b = Lead3 | {4'b0000, cp[15:12]};
        default: b = Lead4 | {5'b00000, cp[20:18]};
      endcase
    end else begin
      b = Cont | {2'b00, six};
    end
    return b;
  endfunction

endpackage

>>> rtl/u16u8_fifo.sv
// small job queue between the classifying front and the byte serializer
// depends on u16u8_pkg
module u16u8_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  u16u8_pkg::entry_t push_data_i,
  output logic              full_o,
  output logic              head_valid_o,
  output u16u8_pkg::entry_t head_o,
  input  logic              pop_i
);

  u16u8_pkg::entry_t            slots_q [u16u8_pkg::QDepth];
  logic [u16u8_pkg::QAw-1:0]    wr_ptr_q, wr_ptr_d;
  logic [u16u8_pkg::QAw-1:0]    rd_ptr_q, rd_ptr_d;
  logic [u16u8_pkg::QCw-1:0]    count_q, count_d;

  // status
  assign full_o       = (count_q == u16u8_pkg::QCw'(u16u8_pkg::QDepth));
  assign head_valid_o = (count_q != '0);
  assign head_o       = slots_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // slot storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> rtl/u16u8_front.sv
// front: accepts code units, pairs surrogates and builds queue jobs
// depends on u16u8_pkg
module u16u8_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [15:0]       code_unit_i,
  input  logic              unit_last_i,
  input  logic              q_full_i,
  output logic              push_o,
  output u16u8_pkg::entry_t push_data_o
);

  logic       held_q, held_d;
  logic [9:0] held_bits_q, held_bits_d;
  logic       accept;
  logic       is_high, is_low;
  u16u8_pkg::entry_t job;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign is_high    = (code_unit_i[15:10] == u16u8_pkg::HighPrefix);
  assign is_low     = (code_unit_i[15:10] == u16u8_pkg::LowPrefix);

  // classify the unit against the held high surrogate
  always_comb begin
    job           = '0;
    job.last      = unit_last_i;
    job.pre_bits  = held_bits_q;
    held_d        = held_q;
    held_bits_d   = held_bits_q;
    if (held_q && is_low) begin
      job.cur_valid = 1'b1;
      job.cp        = u16u8_pkg::SuppBase + {1'b0, held_bits_q, code_unit_i[9:0]};
      job.len_m1    = u16u8_pkg::Len4;
      held_d        = 1'b0;
    end else begin
      job.pre_valid = held_q;
      held_d        = 1'b0;
      if (is_high && !unit_last_i) begin
        held_d      = 1'b1;
        held_bits_d = code_unit_i[9:0];
      end else begin
        job.cur_valid = 1'b1;
        job.cp        = {5'b00000, code_unit_i};
        if (code_unit_i <= u16u8_pkg::Max1Byte) begin
          job.len_m1 = u16u8_pkg::Len1;
        end else if (code_unit_i <= u16u8_pkg::Max2Byte) begin
          job.len_m1 = u16u8_pkg::Len2;
        end else begin
          job.len_m1 = u16u8_pkg::Len3;
        end
      end
    end
  end

  // only jobs that emit bytes enter the queue
  assign push_o      = accept && (job.pre_valid || job.cur_valid);
  assign push_data_o = job;

  // held surrogate state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= 1'b0;
      held_bits_q <= '0;
    end else if (accept) begin
      held_q      <= held_d;
      held_bits_q <= held_bits_d;
    end
  end

endmodule

>>> rtl/u16u8_back.sv
// back: serializes one queued job into utf-8 bytes, one word per cycle while not stalled
// depends on u16u8_pkg
module u16u8_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_valid_i,
  input  u16u8_pkg::entry_t head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        out_byte_o,
  output logic              run_last_o,
  output logic              string_end_o
);

  logic        out_valid_q, out_valid_d;
  logic [7:0]  byte_q;
  logic        run_last_q, string_end_q;
  logic        pre_done_q, pre_done_d;
  logic [1:0]  idx_q, idx_d;
  logic        load;
  logic        seg_pre, seg_end;
  logic [20:0] seg_cp;
  logic [1:0]  seg_len;
  logic [7:0]  seg_byte;

  // current segment: flushed high surrogate first, then the code point
  assign seg_pre  = head_i.pre_valid && !pre_done_q;
  assign seg_cp   = seg_pre ? {5'b00000, u16u8_pkg::HighPrefix, head_i.pre_bits} : head_i.cp;
  assign seg_len  = seg_pre ? u16u8_pkg::Len3 : head_i.len_m1;
  assign seg_end  = (idx_q == seg_len);
  assign seg_byte = u16u8_pkg::enc_byte(seg_cp, seg_len, idx_q);

  assign load  = head_valid_i && (!out_valid_q || !out_stall_i);
  assign pop_o = load && seg_end && !(seg_pre && head_i.cur_valid);

  // byte position and segment tracking
  always_comb begin
    idx_d       = idx_q;
    pre_done_d  = pre_done_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (load) begin
      out_valid_d = 1'b1;
      if (seg_end) begin
        idx_d      = 2'd0;
        pre_done_d = !pop_o;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= 2'd0;
      pre_done_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      pre_done_q  <= pre_done_d;
    end
  end

  // output word register
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q       <= seg_byte;
      run_last_q   <= pop_o;
      string_end_q <= pop_o && head_i.last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = byte_q;
  assign run_last_o   = run_last_q;
  assign string_end_o = string_end_q;

endmodule

>>> rtl/utf16_to_utf8_transcoder.sv
// channel | dir | word                               | handshake
// input   | in  | code_unit_i, unit_last_i           | in_valid_i / in_stall_o
// output  | out | out_byte_o, run_last_o, string_end_o | out_valid_o / out_stall_i
//
// output carries one utf-8 byte per cycle while not stalled; the bytes that a unit causes
// number 0 for a held high surrogate, 1 to 4, or up to 6 with a flushed surrogate
// the byte serializer in the back sets the rate; input is taken each cycle while
// the two-entry job queue has room; a byte passes the job queue, then the output register
// reset clears the held surrogate, the queue and the output valid flag; no clear pass
// in_stall_o rises only when the queue is full; output stalls never lose a byte
// top level of the utf-16 to utf-8 transcoder
// depends on u16u8_pkg, u16u8_front, u16u8_fifo, u16u8_back and the macro header
`include "utf16_to_utf8_transcoder_macros.svh"

module utf16_to_utf8_transcoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] code_unit_i,
  input  logic        unit_last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        run_last_o,
  output logic        string_end_o
);

  logic              push;
  logic              q_full;
  logic              head_valid;
  logic              pop;
  u16u8_pkg::entry_t push_data;
  u16u8_pkg::entry_t head;

  // classify and pair surrogates
  u16u8_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .code_unit_i (code_unit_i),
    .unit_last_i (unit_last_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // job queue
  u16u8_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_data),
    .full_o       (q_full),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  // byte serializer
  u16u8_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .run_last_o   (run_last_o),
    .string_end_o (string_end_o)
  );

  // checks
  `U16_ASSERT_NEVER(a_push_when_full, push && q_full, "job pushed into a full queue")
  `U16_ASSERT(a_pop_marks_run, pop |=> (out_valid_o && run_last_o), "retired job without run end")
  `U16_ASSERT_NEVER(a_end_outside_run, out_valid_o && string_end_o && !run_last_o, "string end off run end")

endmodule
